// ===== design/jhd_pkg.sv =====
// Shared types and constants for the JPEG Huffman block decoder.
// Depends on nothing; imported by the top level.
package jhd_pkg;

  localparam int MaxSymbols  = 256;
  localparam int BlockCoefs  = 64;
  localparam int CoefBits    = 16;
  localparam int MaxCodeLen  = 16;
  localparam int MaxMagSize  = 11;

  localparam int CountDepth  = 64;
  localparam int SymbolDepth = 1024;

  localparam logic [15:0] CoefMask = 16'((32'd1 << CoefBits) - 32'd1);

  localparam logic [7:0] SymEob = 8'h00;
  localparam logic [7:0] SymZrl = 8'hF0;

  typedef enum logic [1:0] {
    ACT_LOAD_COUNT  = 2'd0,
    ACT_LOAD_SYMBOL = 2'd1,
    ACT_SCAN_BIT    = 2'd2,
    ACT_START_SCAN  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CODE = 2'd1,
    PH_MAG  = 2'd2
  } phase_t;

endpackage

// ===== design/jpeg_huffman_block_decoder.sv =====
// Top level of the baseline JPEG Huffman block decoder.
// Depends on jhd_pkg and jhd_ram (count table and symbol table).
//
// Usage: the input channel (in_valid / in_stall) carries table loads, a start
// scan command and entropy-coded bits, one bit per transaction, most
// significant first. The result channel (out_valid / out_stall) carries one
// coefficient per transaction with its zigzag position, component and
// block_last flag, or a single error result after which decoding halts
// until the next start scan.
// Throughput: one scan bit per cycle while a code is being assembled and the
// input is not stalled; each completed Huffman code stalls the input while
// the symbol table is read. A count load stalls the input while the
// prefetched count is refreshed. While coefficients are being emitted
// (zero runs, end of block) the input is stalled and one result leaves per
// cycle unless the receiver stalls, through an output register.
// Reset clears all control state and selects the idle phase; the tables are
// undefined until loaded. If the receiver stalls, the pending result holds
// and the input stays stalled until the emission has drained.
module jpeg_huffman_block_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic               in_table_class,
  input  logic               in_table_id,
  input  logic [7:0]         in_slot,
  input  logic [7:0]         in_load_value,
  input  logic               in_scan_bit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_coefficient,
  output logic [5:0]         out_position,
  output logic [1:0]         out_component,
  output logic               out_block_last,
  output logic               out_decode_error
);
  import jhd_pkg::*;

  localparam int CntAw = $clog2(CountDepth);
  localparam int SymAw = $clog2(SymbolDepth);

  // Code assembly state.
  logic [15:0] acc_r, acc_nxt;
  logic [4:0]  len_r, len_nxt;
  logic [16:0] first_r, first_nxt;
  logic [8:0]  ib_r, ib_nxt;
  logic [7:0]  sym_r, sym_nxt;
  logic [10:0] mb_r, mb_nxt;
  logic [3:0]  ml_r, ml_nxt;
  phase_t      phase_r, phase_nxt;
  logic [5:0]  bp_r, bp_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic        halt_r, halt_nxt;
  logic [15:0] pred_r [3];
  logic [15:0] pred_nxt [3];
  logic        fetch_r, fetch_nxt;
  logic        stale_r, stale_nxt;

  // Emission engine.
  logic [4:0]  zeros_r, zeros_nxt;
  logic        eob_r, eob_nxt;
  logic        valp_r, valp_nxt;
  logic        errp_r, errp_nxt;
  logic [15:0] val_r, val_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] ocoef_r, ocoef_nxt;
  logic [5:0]  opos_r, opos_nxt;
  logic [1:0]  ocomp_r, ocomp_nxt;
  logic        olast_r, olast_nxt;
  logic        oerr_r, oerr_nxt;

  // Memory ports.
  logic             cnt_we, sym_we;
  logic [CntAw-1:0] cnt_waddr, cnt_raddr;
  logic [SymAw-1:0] sym_waddr, sym_raddr;
  logic [7:0]       cnt_rdata, sym_rdata;

  logic accept, eng_active, push_ok;
  logic go_idle, go_code, go_mag;

  // Working values of the combinational update.
  logic        do_raise, do_finish, last;
  logic [7:0]  fin_sym;
  logic [10:0] fin_bits;
  logic [3:0]  fs, tr;
  logic [15:0] mask16, mv16, half16, ext16, sumc, sumx;
  logic [15:0] acc_n;
  logic [4:0]  len_n;
  logic [16:0] diff17;
  logic        match;
  logic [9:0]  idx10, ib_sum;
  logic [18:0] f19;
  logic [1:0]  cur_tbl;
  logic [6:0]  bp_ext;

  assign eng_active = eob_r || (zeros_r != 5'd0) || valp_r || errp_r;
  assign push_ok    = !out_valid_r || !out_stall;
  assign in_stall   = fetch_r || stale_r || eng_active;
  assign accept     = in_valid && !in_stall;
  assign cur_tbl    = {bp_r != 6'd0, comp_r != 2'd0};
  assign bp_ext     = {1'b0, bp_r};

  assign cnt_we    = accept && (in_action == ACT_LOAD_COUNT) && (in_slot < 8'd16);
  assign cnt_waddr = {in_table_class, in_table_id, in_slot[3:0]};
  assign sym_we    = accept && (in_action == ACT_LOAD_SYMBOL)
                     && ({1'b0, in_slot} < 9'(MaxSymbols));
  assign sym_waddr = {in_table_class, in_table_id, in_slot};

  // The count for the next code length is prefetched from the next state.
  assign cnt_raddr = {bp_nxt != 6'd0, comp_nxt != 2'd0, len_nxt[3:0]};

  jhd_ram #(.Width(8), .Depth(CountDepth)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (in_load_value),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  jhd_ram #(.Width(8), .Depth(SymbolDepth)) u_symbol_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (sym_waddr),
    .wdata (in_load_value),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  always_comb begin
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    ib_nxt    = ib_r;
    sym_nxt   = sym_r;
    mb_nxt    = mb_r;
    ml_nxt    = ml_r;
    bp_nxt    = bp_r;
    comp_nxt  = comp_r;
    halt_nxt  = halt_r;
    for (int i = 0; i < 3; i++) begin
      pred_nxt[i] = pred_r[i];
    end
    fetch_nxt = 1'b0;
    stale_nxt = 1'b0;
    zeros_nxt = zeros_r;
    eob_nxt   = eob_r;
    valp_nxt  = valp_r;
    errp_nxt  = errp_r;
    val_nxt   = val_r;
    out_valid_nxt = out_valid_r && out_stall;
    ocoef_nxt = ocoef_r;
    opos_nxt  = opos_r;
    ocomp_nxt = ocomp_r;
    olast_nxt = olast_r;
    oerr_nxt  = oerr_r;
    sym_raddr = '0;
    go_idle   = 1'b0;
    go_code   = 1'b0;
    go_mag    = 1'b0;
    do_raise  = 1'b0;
    do_finish = 1'b0;
    fin_sym   = sym_r;
    fin_bits  = mb_r;
    last      = (bp_r == 6'(BlockCoefs - 1));
    acc_n     = {acc_r[14:0], in_scan_bit};
    len_n     = len_r + 5'd1;
    diff17    = {1'b0, acc_n} - first_r;
    match     = ({1'b0, acc_n} >= first_r) && (diff17 < {9'd0, cnt_rdata});
    idx10     = {1'b0, ib_r} + {2'd0, diff17[7:0]};
    ib_sum    = {1'b0, ib_r} + {2'd0, cnt_rdata};
    f19       = {({1'b0, first_r} + {10'd0, cnt_rdata}), 1'b0};
    tr        = sym_rdata[7:4];

    // Emission: one result per cycle unless the output is stalled, error first, then runs, then value.
    if (eng_active && push_ok) begin
      out_valid_nxt = 1'b1;
      opos_nxt  = bp_r;
      ocomp_nxt = comp_r;
      ocoef_nxt = '0;
      olast_nxt = last;
      oerr_nxt  = 1'b0;
      if (errp_r) begin
        errp_nxt  = 1'b0;
        olast_nxt = 1'b0;
        oerr_nxt  = 1'b1;
      end else begin
        if (eob_r) begin
          if (last) begin
            eob_nxt = 1'b0;
          end
        end else if (zeros_r != 5'd0) begin
          zeros_nxt = zeros_r - 5'd1;
        end else begin
          ocoef_nxt = val_r;
          valp_nxt  = 1'b0;
        end
        bp_nxt = bp_r + 6'd1;
        if (last) begin
          bp_nxt   = '0;
          comp_nxt = (comp_r >= 2'd2) ? 2'd0 : comp_r + 2'd1;
        end
      end
    end

    // Symbol arrives in the cycle after the table read was issued.
    if (fetch_r) begin
      sym_nxt = sym_rdata;
      mb_nxt  = '0;
      if (bp_r == 6'd0) begin
        if (tr != 4'd0 || sym_rdata[3:0] > 4'(MaxMagSize)) begin
          do_raise = 1'b1;
        end else if (sym_rdata[3:0] == 4'd0) begin
          do_finish = 1'b1;
          fin_sym   = sym_rdata;
          fin_bits  = '0;
        end else begin
          ml_nxt = sym_rdata[3:0];
          go_mag = 1'b1;
        end
      end else if (sym_rdata == SymEob) begin
        eob_nxt = 1'b1;
      end else if (sym_rdata == SymZrl) begin
        if (bp_ext + 7'd16 > 7'(BlockCoefs)) begin
          do_raise = 1'b1;
        end else begin
          zeros_nxt = 5'd16;
        end
      end else if (sym_rdata[3:0] == 4'd0 || sym_rdata[3:0] > 4'(MaxMagSize)) begin
        do_raise = 1'b1;
      end else if (bp_ext + {3'd0, tr} + 7'd1 > 7'(BlockCoefs)) begin
        do_raise = 1'b1;
      end else begin
        ml_nxt = sym_rdata[3:0];
        go_mag = 1'b1;
      end
    end

    if (accept) begin
      case (in_action)
        ACT_LOAD_COUNT: begin
          stale_nxt = 1'b1;
        end
        ACT_START_SCAN: begin
          for (int i = 0; i < 3; i++) begin
            pred_nxt[i] = '0;
          end
          acc_nxt   = '0;
          len_nxt   = '0;
          first_nxt = '0;
          ib_nxt    = '0;
          sym_nxt   = '0;
          mb_nxt    = '0;
          ml_nxt    = '0;
          bp_nxt    = '0;
          comp_nxt  = '0;
          halt_nxt  = 1'b0;
          go_code   = 1'b1;
        end
        ACT_SCAN_BIT: begin
          if (!halt_r && phase_r == PH_MAG) begin
            mb_nxt = {mb_r[9:0], in_scan_bit};
            if (ml_r <= 4'd1) begin
              ml_nxt    = '0;
              do_finish = 1'b1;
              fin_bits  = {mb_r[9:0], in_scan_bit};
            end else begin
              ml_nxt = ml_r - 4'd1;
            end
          end else if (!halt_r && phase_r == PH_CODE) begin
            if (match) begin
              acc_nxt   = '0;
              len_nxt   = '0;
              first_nxt = '0;
              ib_nxt    = '0;
              if (idx10 >= 10'(MaxSymbols)) begin
                do_raise = 1'b1;
              end else begin
                fetch_nxt = 1'b1;
                sym_raddr = {cur_tbl, idx10[7:0]};
              end
            end else begin
              acc_nxt   = acc_n;
              len_nxt   = len_n;
              ib_nxt    = (ib_sum > 10'(MaxSymbols)) ? 9'(MaxSymbols) : ib_sum[8:0];
              first_nxt = (f19 > 19'h1FFFF) ? 17'h1FFFF : f19[16:0];
              if (len_n >= 5'(MaxCodeLen)) begin
                do_raise = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Magnitude extension and, for DC, the predictor update.
    fs     = fin_sym[3:0];
    mask16 = (16'd1 << fs) - 16'd1;
    mv16   = {5'd0, fin_bits} & mask16;
    half16 = (fs == 4'd0) ? 16'd0 : (16'd1 << (fs - 4'd1));
    if (fs == 4'd0) begin
      ext16 = '0;
    end else if (mv16 < half16) begin
      ext16 = mv16 + 16'd1 - (16'd1 << fs);
    end else begin
      ext16 = mv16;
    end
    sumc = (pred_r[comp_r] + ext16) & CoefMask;
    sumx = sumc[CoefBits-1] ? (sumc | ~CoefMask) : sumc;
    if (do_finish) begin
      mb_nxt   = '0;
      ml_nxt   = '0;
      go_code  = 1'b1;
      valp_nxt = 1'b1;
      if (bp_r == 6'd0) begin
        pred_nxt[comp_r] = sumc;
        val_nxt = sumx;
      end else begin
        zeros_nxt = {1'b0, fin_sym[7:4]};
        val_nxt   = ext16;
      end
    end

    if (do_raise) begin
      errp_nxt  = 1'b1;
      halt_nxt  = 1'b1;
      go_idle   = 1'b1;
      acc_nxt   = '0;
      len_nxt   = '0;
      first_nxt = '0;
      ib_nxt    = '0;
    end
  end

  // Phase sequencing.
  always_comb begin
    phase_nxt = phase_r;
    if (go_idle) begin
      phase_nxt = PH_IDLE;
    end else if (go_mag) begin
      phase_nxt = PH_MAG;
    end else if (go_code) begin
      phase_nxt = PH_CODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      len_r       <= '0;
      first_r     <= '0;
      ib_r        <= '0;
      sym_r       <= '0;
      mb_r        <= '0;
      ml_r        <= '0;
      phase_r     <= PH_IDLE;
      bp_r        <= '0;
      comp_r      <= '0;
      halt_r      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pred_r[i] <= '0;
      end
      fetch_r     <= 1'b0;
      stale_r     <= 1'b0;
      zeros_r     <= '0;
      eob_r       <= 1'b0;
      valp_r      <= 1'b0;
      errp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      len_r       <= len_nxt;
      first_r     <= first_nxt;
      ib_r        <= ib_nxt;
      sym_r       <= sym_nxt;
      mb_r        <= mb_nxt;
      ml_r        <= ml_nxt;
      phase_r     <= phase_nxt;
      bp_r        <= bp_nxt;
      comp_r      <= comp_nxt;
      halt_r      <= halt_nxt;
      for (int i = 0; i < 3; i++) begin
        pred_r[i] <= pred_nxt[i];
      end
      fetch_r     <= fetch_nxt;
      stale_r     <= stale_nxt;
      zeros_r     <= zeros_nxt;
      eob_r       <= eob_nxt;
      valp_r      <= valp_nxt;
      errp_r      <= errp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    ocoef_r <= ocoef_nxt;
    opos_r  <= opos_nxt;
    ocomp_r <= ocomp_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_coefficient  = ocoef_r;
  assign out_position     = opos_r;
  assign out_component    = ocomp_r;
  assign out_block_last   = olast_r;
  assign out_decode_error = oerr_r;

  a_fetch_single: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_r |=> !fetch_r)
    else $error("symbol fetch held for more than one cycle");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    errp_r |-> (halt_r && phase_r == PH_IDLE))
    else $error("pending error result without halt");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && oerr_r) |-> (ocoef_r == 16'd0 && !olast_r))
    else $error("error result carries a coefficient");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && olast_r) |-> (opos_r == 6'(BlockCoefs - 1)))
    else $error("block end flagged away from the final position");

endmodule

// ===== design/jhd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Self-contained; used for the code count and symbol tables.
module jhd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
